// ===== design/cic_pkg.sv =====
// Shared types, codes and priority helpers for the cascaded interrupt controller.
// Used by cic_chip_next, the top level and the testbench.
package cic_pkg;

    // Item kinds
    localparam logic [1:0] K_LINE  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;
    localparam logic [1:0] K_ACK   = 2'd3;

    // Initialization sequence steps
    localparam logic [1:0] STEP_READY = 2'd0;
    localparam logic [1:0] STEP_ICW2  = 2'd1;
    localparam logic [1:0] STEP_ICW3  = 2'd2;
    localparam logic [1:0] STEP_ICW4  = 2'd3;

    // OCW2 command codes (bits 7..5)
    localparam logic [2:0] OCW2_ROT_AEOI_CLR = 3'd0;
    localparam logic [2:0] OCW2_NS_EOI       = 3'd1;
    localparam logic [2:0] OCW2_NOP          = 3'd2;
    localparam logic [2:0] OCW2_SP_EOI       = 3'd3;
    localparam logic [2:0] OCW2_ROT_AEOI_SET = 3'd4;
    localparam logic [2:0] OCW2_ROT_NS_EOI   = 3'd5;
    localparam logic [2:0] OCW2_SET_PRIO     = 3'd6;
    localparam logic [2:0] OCW2_ROT_SP_EOI   = 3'd7;

    // Mode flag bit positions
    localparam int unsigned F_RSEL = 0;
    localparam int unsigned F_SMM  = 1;
    localparam int unsigned F_AEOI = 2;
    localparam int unsigned F_ROT  = 3;
    localparam int unsigned F_ICW4 = 4;

    // Command byte bits
    localparam int unsigned CMD_ICW1 = 4;
    localparam int unsigned CMD_OCW3 = 3;

    localparam logic [7:0] ICW1_UNSUP_MASK = 8'h0a;
    localparam logic [7:0] BASE_MASK       = 8'hf8;
    localparam logic [7:0] ELCR_M_MASK     = 8'hf8;
    localparam logic [7:0] ELCR_S_MASK     = 8'hde;
    localparam logic [2:0] CASCADE_LINE    = 3'd2;
    localparam logic [2:0] SPURIOUS_LINE   = 3'd7;

    // Config register indexes
    localparam logic CFG_ELCR_M = 1'b0;
    localparam logic CFG_ELCR_S = 1'b1;

    // Per-chip state
    typedef struct packed {
        logic [7:0] irr;
        logic [7:0] llb;
        logic [7:0] imr;
        logic [7:0] isr;
        logic [2:0] prio;
        logic [7:0] base;
        logic [1:0] step;
        logic [4:0] flags;
    } t_chip;

    // Per-chip operation for one request
    typedef struct packed {
        logic       do_line;
        logic       do_cmd;
        logic       do_data;
        logic       do_take;
        logic [2:0] line;
        logic       level;
        logic [7:0] data;
    } t_chip_op;

    typedef struct packed {
        logic       valid;
        logic [2:0] line;
    } t_pass;

    // Rank of the highest-priority set bit; 8 when none is set
    function automatic logic [3:0] f_rank(logic [7:0] bits, logic [2:0] off);
        logic [15:0] dbl;
        logic [7:0]  rot;
        logic [3:0]  r;
        dbl = {bits, bits} >> off;
        rot = dbl[7:0];
        r   = 4'd8;
        for (int p = 7; p >= 0; p--) begin
            if (rot[p]) r = 4'(p);
        end
        return r;
    endfunction

    // Request that outranks every in-service line, if any
    function automatic t_pass f_pass(t_chip c);
        logic [3:0] pr;
        logic [3:0] ps;
        t_pass      r;
        pr      = f_rank(c.irr & ~c.imr, c.prio);
        ps      = f_rank(c.isr, c.prio);
        r.valid = !pr[3] && (pr < ps);
        r.line  = 3'(pr[2:0] + c.prio);
        return r;
    endfunction

    // New level on one line, edge or level triggered
    function automatic t_chip f_drive(t_chip c, logic [7:0] trig, logic [2:0] n, logic lvl);
        t_chip      r;
        logic [7:0] b;
        r = c;
        b = 8'b1 << n;
        if (|(trig & b)) begin
            if (lvl) begin
                r.irr = c.irr | b;
                r.llb = c.llb | b;
            end else begin
                r.irr = c.irr & ~b;
                r.llb = c.llb & ~b;
            end
        end else if (lvl) begin
            if (!(|(c.llb & b))) r.irr = c.irr | b;
            r.llb = c.llb | b;
        end else begin
            r.llb = c.llb & ~b;
        end
        return r;
    endfunction

endpackage

// ===== design/cic_in_if.sv =====
// Request channel of the cascaded interrupt controller: valid/ready and item fields.
// Depends on nothing.
interface cic_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       chip_select;
    logic       port;
    logic [3:0] irq_line;
    logic       level;
    logic [7:0] write_data;

    modport source (
        output valid, kind, chip_select, port, irq_line, level, write_data,
        input  ready
    );
    modport sink (
        input  valid, kind, chip_select, port, irq_line, level, write_data,
        output ready
    );
endinterface

// ===== design/cic_out_if.sv =====
// Response channel of the cascaded interrupt controller: valid/ready and result fields.
// Depends on nothing.
interface cic_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] vector;
    logic       cpu_irq;
    logic       unsupported;

    modport source (
        output valid, read_data, vector, cpu_irq, unsupported,
        input  ready
    );
    modport sink (
        input  valid, read_data, vector, cpu_irq, unsupported,
        output ready
    );
endinterface

// ===== design/cascaded_interrupt_controller.sv =====
// Top level of the cascaded interrupt controller (master and slave 8259A pair).
// Depends on cic_pkg, cic_in_if, cic_out_if and cic_chip_next.
//
// Usage:
//   i_req carries one request per valid/ready handshake: a line level change,
//   a register write, a register read or an interrupt acknowledge. o_rsp returns
//   exactly one response per request, in order, with read data, the vector, the
//   processor interrupt line after the request and the unsupported-ICW1 flag.
//   The level-trigger registers are written through i_cfg_we/i_cfg_idx/
//   i_cfg_data while no request is in flight; they take effect at once.
// Pipeline:
//   A request is held in an input register; when it moves on, the chip updates
//   and the cascade/CPU line evaluation run in one pass of priority encoders
//   into the response register, which drives o_rsp.valid. One request is
//   accepted every cycle while o_rsp is not held off.
// Reset:
//   Synchronous active-low reset clears both chips, the CPU line, the level
//   trigger registers and both channel stages.
// Stall:
//   When o_rsp is held off, the response register keeps its value, the input
//   register fills once, and i_req.ready then drops until the response drains.
module cascaded_interrupt_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    cic_in_if.sink     i_req,
    cic_out_if.source  o_rsp
);

    // Input register
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic       r_cs;
    logic       r_port;
    logic [3:0] r_line;
    logic       r_level;
    logic [7:0] r_wdata;

    // Response register
    logic       r_out_valid;
    logic [7:0] r_rdata;
    logic [7:0] r_vector;
    logic       r_cpu_irq;
    logic       r_unsup;

    // Controller state
    cic_pkg::t_chip r_mst;
    cic_pkg::t_chip r_slv;
    logic           r_cpu_line;
    logic [7:0]     r_elcr_m;
    logic [7:0]     r_elcr_s;

    logic             accept;
    logic             advance;
    cic_pkg::t_pass   m_pass;
    cic_pkg::t_pass   s_pass;
    cic_pkg::t_chip_op op_m;
    cic_pkg::t_chip_op op_s;
    cic_pkg::t_chip   mst_upd;
    cic_pkg::t_chip   slv_upd;
    logic             unsup_m;
    logic             unsup_s;
    cic_pkg::t_pass   s_pass_upd;
    cic_pkg::t_chip   mst_pulse;
    cic_pkg::t_pass   m_pass_upd;
    cic_pkg::t_chip   n_mst;
    cic_pkg::t_chip   n_slv;
    logic             n_cpu_line;
    logic [7:0]       n_rdata;
    logic [7:0]       n_vector;
    cic_pkg::t_chip   sel_chip;

    // Handshake: input register drains into the response register
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_req.kind;
            r_cs    <= i_req.chip_select;
            r_port  <= i_req.port;
            r_line  <= i_req.irq_line;
            r_level <= i_req.level;
            r_wdata <= i_req.write_data;
        end
    end

    // Level-trigger configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elcr_m <= '0;
            r_elcr_s <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cic_pkg::CFG_ELCR_M: r_elcr_m <= i_cfg_data & cic_pkg::ELCR_M_MASK;
                cic_pkg::CFG_ELCR_S: r_elcr_s <= i_cfg_data & cic_pkg::ELCR_S_MASK;
                default: ;
            endcase
        end
    end

    // Passable requests before the request is applied (acknowledge path)
    assign m_pass = cic_pkg::f_pass(r_mst);
    assign s_pass = cic_pkg::f_pass(r_slv);

    // Per-chip operation decode
    always_comb begin
        op_m         = '0;
        op_s         = '0;
        op_m.level   = r_level;
        op_s.level   = r_level;
        op_m.data    = r_wdata;
        op_s.data    = r_wdata;
        op_m.do_line = (r_kind == cic_pkg::K_LINE) && !r_line[3];
        op_s.do_line = (r_kind == cic_pkg::K_LINE) && r_line[3];
        op_m.do_cmd  = (r_kind == cic_pkg::K_WRITE) && !r_port && !r_cs;
        op_s.do_cmd  = (r_kind == cic_pkg::K_WRITE) && !r_port && r_cs;
        op_m.do_data = (r_kind == cic_pkg::K_WRITE) && r_port && !r_cs;
        op_s.do_data = (r_kind == cic_pkg::K_WRITE) && r_port && r_cs;
        op_m.do_take = (r_kind == cic_pkg::K_ACK) && m_pass.valid;
        op_s.do_take = (r_kind == cic_pkg::K_ACK) && m_pass.valid
                       && (m_pass.line == cic_pkg::CASCADE_LINE) && s_pass.valid;
        op_m.line    = op_m.do_take ? m_pass.line : r_line[2:0];
        op_s.line    = op_s.do_take ? s_pass.line : r_line[2:0];
    end

    cic_chip_next u_mst_next (
        .i_cur         (r_mst),
        .i_trig        (r_elcr_m),
        .i_op          (op_m),
        .o_next        (mst_upd),
        .o_unsupported (unsup_m)
    );

    cic_chip_next u_slv_next (
        .i_cur         (r_slv),
        .i_trig        (r_elcr_s),
        .i_op          (op_s),
        .o_next        (slv_upd),
        .o_unsupported (unsup_s)
    );

    // Cascade pulse on master line 2, then the CPU line
    assign s_pass_upd = cic_pkg::f_pass(slv_upd);
    assign mst_pulse  = s_pass_upd.valid
        ? cic_pkg::f_drive(cic_pkg::f_drive(mst_upd, r_elcr_m, cic_pkg::CASCADE_LINE, 1'b1),
                           r_elcr_m, cic_pkg::CASCADE_LINE, 1'b0)
        : mst_upd;
    assign m_pass_upd = cic_pkg::f_pass(mst_pulse);

    // Reads leave the state untouched
    always_comb begin
        if (r_kind == cic_pkg::K_READ) begin
            n_mst      = r_mst;
            n_slv      = r_slv;
            n_cpu_line = r_cpu_line;
        end else begin
            n_mst      = mst_pulse;
            n_slv      = slv_upd;
            n_cpu_line = m_pass_upd.valid;
        end
    end

    // Read data
    assign sel_chip = r_cs ? r_slv : r_mst;
    always_comb begin
        n_rdata = '0;
        if (r_kind == cic_pkg::K_READ) begin
            if (r_port) n_rdata = sel_chip.imr;
            else if (sel_chip.flags[cic_pkg::F_RSEL]) n_rdata = sel_chip.isr;
            else n_rdata = sel_chip.irr;
        end
    end

    // Acknowledge vector; spurious gives base plus 7
    always_comb begin
        n_vector = '0;
        if (r_kind == cic_pkg::K_ACK) begin
            if (!m_pass.valid) begin
                n_vector = r_mst.base + {5'd0, cic_pkg::SPURIOUS_LINE};
            end else if (m_pass.line == cic_pkg::CASCADE_LINE) begin
                n_vector = r_slv.base + {5'd0, s_pass.valid ? s_pass.line
                                                            : cic_pkg::SPURIOUS_LINE};
            end else begin
                n_vector = r_mst.base + {5'd0, m_pass.line};
            end
        end
    end

    // State commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mst      <= '0;
            r_slv      <= '0;
            r_cpu_line <= 1'b0;
        end else if (advance) begin
            r_mst      <= n_mst;
            r_slv      <= n_slv;
            r_cpu_line <= n_cpu_line;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rdata   <= n_rdata;
            r_vector  <= n_vector;
            r_cpu_irq <= n_cpu_line;
            r_unsup   <= unsup_m | unsup_s;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_rdata;
    assign o_rsp.vector      = r_vector;
    assign o_rsp.cpu_irq     = r_cpu_irq;
    assign o_rsp.unsupported = r_unsup;

    // The response on offer always reports the current CPU line
    a_cpu_line_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_cpu_irq == r_cpu_line))
        else $error("response cpu_irq differs from the CPU line state");

    // In-service bits are set only by an acknowledge
    a_isr_only_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(advance) && ($past(r_kind) != cic_pkg::K_ACK)
        |-> ((r_mst.isr & ~$past(r_mst.isr)) == 8'h00)
         && ((r_slv.isr & ~$past(r_slv.isr)) == 8'h00))
        else $error("in-service bit set without an acknowledge");

    // A held request is never overwritten while the response side stalls
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_rsp.ready |-> !i_req.ready)
        else $error("request accepted into a full stage");

    // State changes only when a request moves on
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(advance)
        |-> (r_mst == $past(r_mst)) && (r_slv == $past(r_slv)))
        else $error("chip state changed without a request");

endmodule

// ===== design/cic_chip_next.sv =====
// Next state of one 8259A-style chip for a line change, register write or acknowledge.
// Depends on cic_pkg.
module cic_chip_next (
    input  cic_pkg::t_chip    i_cur,
    input  logic [7:0]        i_trig,
    input  cic_pkg::t_chip_op i_op,
    output cic_pkg::t_chip    o_next,
    output logic              o_unsupported
);

    cic_pkg::t_chip n_chip;
    logic [3:0]     svc_rank;
    logic [2:0]     eoi_line;
    logic [7:0]     v;
    logic [7:0]     tk_bit;

    assign v        = i_op.data;
    assign svc_rank = cic_pkg::f_rank(i_cur.isr, i_cur.prio);
    assign eoi_line = 3'(svc_rank[2:0] + i_cur.prio);
    assign tk_bit   = 8'b1 << i_op.line;

    always_comb begin
        n_chip        = i_cur;
        o_unsupported = 1'b0;

        // Line level change
        if (i_op.do_line) begin
            n_chip = cic_pkg::f_drive(i_cur, i_trig, i_op.line, i_op.level);
        end

        // Acknowledge taken on this chip
        if (i_op.do_take) begin
            if (i_cur.flags[cic_pkg::F_AEOI]) begin
                if (i_cur.flags[cic_pkg::F_ROT]) n_chip.prio = 3'(i_op.line + 3'd1);
            end else begin
                n_chip.isr = i_cur.isr | tk_bit;
            end
            if (!(|(i_trig & tk_bit))) n_chip.irr = i_cur.irr & ~tk_bit;
        end

        // Command port: ICW1, OCW3 or OCW2
        if (i_op.do_cmd) begin
            if (v[cic_pkg::CMD_ICW1]) begin
                n_chip        = '0;
                n_chip.step   = cic_pkg::STEP_ICW2;
                n_chip.flags[cic_pkg::F_ICW4] = v[0];
                o_unsupported = |(v & cic_pkg::ICW1_UNSUP_MASK);
            end else if (v[cic_pkg::CMD_OCW3]) begin
                if (v[1]) n_chip.flags[cic_pkg::F_RSEL] = v[0];
                if (v[6]) n_chip.flags[cic_pkg::F_SMM]  = v[5];
            end else begin
                unique case (v[7:5]) inside
                    cic_pkg::OCW2_ROT_AEOI_CLR: n_chip.flags[cic_pkg::F_ROT] = 1'b0;
                    cic_pkg::OCW2_ROT_AEOI_SET: n_chip.flags[cic_pkg::F_ROT] = 1'b1;
                    cic_pkg::OCW2_NS_EOI, cic_pkg::OCW2_ROT_NS_EOI: begin
                        if (!svc_rank[3]) begin
                            n_chip.isr = i_cur.isr & ~(8'b1 << eoi_line);
                            if (v[7]) n_chip.prio = 3'(eoi_line + 3'd1);
                        end
                    end
                    cic_pkg::OCW2_SP_EOI: n_chip.isr = i_cur.isr & ~(8'b1 << v[2:0]);
                    cic_pkg::OCW2_SET_PRIO: n_chip.prio = 3'(v[2:0] + 3'd1);
                    cic_pkg::OCW2_ROT_SP_EOI: begin
                        n_chip.isr  = i_cur.isr & ~(8'b1 << v[2:0]);
                        n_chip.prio = 3'(v[2:0] + 3'd1);
                    end
                    default: ; // no-op code
                endcase
            end
        end

        // Data port: mask or init sequence
        if (i_op.do_data) begin
            unique case (i_cur.step)
                cic_pkg::STEP_READY: n_chip.imr = v;
                cic_pkg::STEP_ICW2: begin
                    n_chip.base = v & cic_pkg::BASE_MASK;
                    n_chip.step = cic_pkg::STEP_ICW3;
                end
                cic_pkg::STEP_ICW3: begin
                    n_chip.step = i_cur.flags[cic_pkg::F_ICW4] ? cic_pkg::STEP_ICW4
                                                               : cic_pkg::STEP_READY;
                end
                cic_pkg::STEP_ICW4: begin
                    n_chip.flags[cic_pkg::F_AEOI] = v[1];
                    n_chip.step = cic_pkg::STEP_READY;
                end
                default: ;
            endcase
        end
    end

    assign o_next = n_chip;

endmodule

// ===== tb/cascaded_interrupt_controller_tb.sv =====
// Self-checking testbench for the cascaded master/slave interrupt controller pair.
// Depends on cic_pkg, cic_in_if, cic_out_if and the cascaded_interrupt_controller RTL.
// A built-in predictor tracks both chips and checks every response in request order.
module cascaded_interrupt_controller_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 48;

    typedef struct packed {
        logic [1:0] kind;
        logic       chip;
        logic       port;
        logic [3:0] irq;
        logic       level;
        logic [7:0] data;
    } t_pic_request;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       cpu_irq;
        logic       unsupported;
    } t_pic_response;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    cic_in_if  req_ch ();
    cic_out_if rsp_ch ();

    cascaded_interrupt_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Predicted state of both chips and the level-trigger registers
    cic_pkg::t_chip pic [2];
    logic [7:0]     trigger_master;
    logic [7:0]     trigger_slave;
    logic           cpu_request;
    t_pic_response  predicted_responses [$];

    // Run bookkeeping
    int  mismatch_count;
    int  requests_sent;
    int  responses_checked;
    int  trigger_settings_used;
    int  cycle_count;
    bit  steady;
    bit  hold_off;
    int  stall_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count++;

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("cascaded_interrupt_controller_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] trigger_bits(int c);
        return c ? trigger_slave : trigger_master;
    endfunction

    // Position of the first set bit counting from the chip's top-priority line; 8 if none
    function automatic int priority_rank(int c, logic [7:0] bits);
        for (int p = 0; p < 8; p++) begin
            if (bits[(p + pic[c].prio) % 8]) return p;
        end
        return 8;
    endfunction

    // Line that would be passed on, or -1
    function automatic int winning_line(int c);
        int req_rank;
        int svc_rank;
        req_rank = priority_rank(c, pic[c].irr & ~pic[c].imr);
        svc_rank = priority_rank(c, pic[c].isr);
        if (req_rank == 8 || req_rank >= svc_rank) return -1;
        return (req_rank + pic[c].prio) % 8;
    endfunction

    function automatic void apply_level(int c, int n, logic lvl);
        logic [7:0] trig;
        trig = trigger_bits(c);
        if (trig[n]) begin
            pic[c].irr[n] = lvl;
            pic[c].llb[n] = lvl;
        end else if (lvl) begin
            if (!pic[c].llb[n]) pic[c].irr[n] = 1'b1;
            pic[c].llb[n] = 1'b1;
        end else begin
            pic[c].llb[n] = 1'b0;
        end
    endfunction

    // Slave request pulses master line 2, then the CPU line follows the master
    function automatic void settle_outputs();
        if (winning_line(1) >= 0) begin
            apply_level(0, cic_pkg::CASCADE_LINE, 1'b1);
            apply_level(0, cic_pkg::CASCADE_LINE, 1'b0);
        end
        cpu_request = (winning_line(0) >= 0);
    endfunction

    function automatic void mark_taken(int c, int n);
        logic [7:0] trig;
        trig = trigger_bits(c);
        if (pic[c].flags[cic_pkg::F_AEOI]) begin
            if (pic[c].flags[cic_pkg::F_ROT]) pic[c].prio = 3'(n + 1);
        end else begin
            pic[c].isr[n] = 1'b1;
        end
        if (!trig[n]) pic[c].irr[n] = 1'b0;
    endfunction

    // Command port: ICW1, OCW3 or OCW2; returns the unsupported-mode flag
    function automatic logic command_write(int c, logic [7:0] v);
        int rank_isr;
        int n;
        n = v[2:0];
        if (v[cic_pkg::CMD_ICW1]) begin
            pic[c] = '0;
            pic[c].step = cic_pkg::STEP_ICW2;
            pic[c].flags[cic_pkg::F_ICW4] = v[0];
            return |(v & cic_pkg::ICW1_UNSUP_MASK);
        end
        if (v[cic_pkg::CMD_OCW3]) begin
            // bit 1 enables the read select, bit 6 the special mask update
            if (v[1]) pic[c].flags[cic_pkg::F_RSEL] = v[0];
            if (v[6]) pic[c].flags[cic_pkg::F_SMM] = v[5];
            return 1'b0;
        end
        case (v[7:5]) inside
            cic_pkg::OCW2_ROT_AEOI_CLR: pic[c].flags[cic_pkg::F_ROT] = 1'b0;
            cic_pkg::OCW2_ROT_AEOI_SET: pic[c].flags[cic_pkg::F_ROT] = 1'b1;
            cic_pkg::OCW2_NS_EOI, cic_pkg::OCW2_ROT_NS_EOI: begin
                rank_isr = priority_rank(c, pic[c].isr);
                if (rank_isr != 8) begin
                    n = (rank_isr + pic[c].prio) % 8;
                    pic[c].isr[n] = 1'b0;
                    if (v[7:5] == cic_pkg::OCW2_ROT_NS_EOI) pic[c].prio = 3'(n + 1);
                end
            end
            cic_pkg::OCW2_SP_EOI: pic[c].isr[n] = 1'b0;
            cic_pkg::OCW2_SET_PRIO: pic[c].prio = 3'(n + 1);
            cic_pkg::OCW2_ROT_SP_EOI: begin
                pic[c].isr[n] = 1'b0;
                pic[c].prio   = 3'(n + 1);
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Data port: mask register when ready, otherwise the next init word
    function automatic void data_write(int c, logic [7:0] v);
        case (pic[c].step)
            cic_pkg::STEP_READY: pic[c].imr = v;
            cic_pkg::STEP_ICW2: begin
                pic[c].base = v & cic_pkg::BASE_MASK;
                pic[c].step = cic_pkg::STEP_ICW3;
            end
            cic_pkg::STEP_ICW3: pic[c].step = pic[c].flags[cic_pkg::F_ICW4]
                                              ? cic_pkg::STEP_ICW4 : cic_pkg::STEP_READY;
            default: begin
                pic[c].flags[cic_pkg::F_AEOI] = v[1];
                pic[c].step = cic_pkg::STEP_READY;
            end
        endcase
    endfunction

    function automatic logic [7:0] acknowledge_vector();
        int         m;
        int         s;
        logic [7:0] vec;
        m = winning_line(0);
        if (m < 0) begin
            vec = pic[0].base + 8'(cic_pkg::SPURIOUS_LINE);
        end else begin
            mark_taken(0, m);
            if (m == cic_pkg::CASCADE_LINE) begin
                s = winning_line(1);
                if (s >= 0) mark_taken(1, s);
                else s = cic_pkg::SPURIOUS_LINE;
                vec = pic[1].base + 8'(s);
            end else begin
                vec = pic[0].base + 8'(m);
            end
        end
        settle_outputs();
        return vec;
    endfunction

    function automatic void predict_pic_response(t_pic_request r);
        t_pic_response rsp;
        rsp = '0;
        case (r.kind)
            cic_pkg::K_LINE: begin
                apply_level(r.irq[3], r.irq[2:0], r.level);
                settle_outputs();
            end
            cic_pkg::K_WRITE: begin
                if (!r.port) rsp.unsupported = command_write(r.chip, r.data);
                else data_write(r.chip, r.data);
                settle_outputs();
            end
            cic_pkg::K_READ: begin
                if (r.port) rsp.read_data = pic[r.chip].imr;
                else if (pic[r.chip].flags[cic_pkg::F_RSEL]) rsp.read_data = pic[r.chip].isr;
                else rsp.read_data = pic[r.chip].irr;
            end
            default: rsp.vector = acknowledge_vector();
        endcase
        rsp.cpu_irq = cpu_request;
        predicted_responses.push_back(rsp);
    endfunction

    // ------------------------------------------------------------------
    // Request builders: fields that the kind does not use stay random
    // ------------------------------------------------------------------

    function automatic t_pic_request random_request();
        t_pic_request r;
        r.kind  = 2'($urandom_range(0, 3));
        r.chip  = 1'($urandom_range(0, 1));
        r.port  = 1'($urandom_range(0, 1));
        r.irq   = 4'($urandom_range(0, 15));
        r.level = 1'($urandom_range(0, 1));
        r.data  = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic t_pic_request line_request(int n, logic lvl);
        t_pic_request r;
        r = random_request();
        r.kind  = cic_pkg::K_LINE;
        r.irq   = 4'(n);
        r.level = lvl;
        return r;
    endfunction

    function automatic t_pic_request write_request(logic chip, logic port, logic [7:0] v);
        t_pic_request r;
        r = random_request();
        r.kind = cic_pkg::K_WRITE;
        r.chip = chip;
        r.port = port;
        r.data = v;
        return r;
    endfunction

    function automatic t_pic_request read_request(logic chip, logic port);
        t_pic_request r;
        r = random_request();
        r.kind = cic_pkg::K_READ;
        r.chip = chip;
        r.port = port;
        return r;
    endfunction

    function automatic t_pic_request ack_request();
        t_pic_request r;
        r = random_request();
        r.kind = cic_pkg::K_ACK;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // One request; valid stays high into the next request when there is no gap
    task automatic send_request(input t_pic_request r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= r.kind;
        req_ch.chip_select <= r.chip;
        req_ch.port        <= r.port;
        req_ch.irq_line    <= r.irq;
        req_ch.level       <= r.level;
        req_ch.write_data  <= r.data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_pic_response(r);
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (predicted_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_trigger_modes(input logic [7:0] master_bits,
                                     input logic [7:0] slave_bits);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= cic_pkg::CFG_ELCR_M;
        i_cfg_data <= master_bits;
        trigger_master = master_bits & cic_pkg::ELCR_M_MASK;
        @(posedge i_clk);
        i_cfg_idx  <= cic_pkg::CFG_ELCR_S;
        i_cfg_data <= slave_bits;
        trigger_slave = slave_bits & cic_pkg::ELCR_S_MASK;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        trigger_settings_used++;
    endtask

    task automatic send_init_sequence(input logic chip, input logic [7:0] icw1,
                                      input logic [7:0] icw2, input logic [7:0] icw3,
                                      input logic [7:0] icw4);
        send_request(write_request(chip, 1'b0, icw1));
        send_request(write_request(chip, 1'b1, icw2));
        send_request(write_request(chip, 1'b1, icw3));
        if (icw1[0]) send_request(write_request(chip, 1'b1, icw4));
    endtask

    task automatic check_response();
        t_pic_response got;
        t_pic_response want;
        got = {rsp_ch.read_data, rsp_ch.vector, rsp_ch.cpu_irq, rsp_ch.unsupported};
        if (predicted_responses.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
        end
        want = predicted_responses.pop_front();
        responses_checked++;
        if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %02h, predicted %02h", got.read_data,
                                      want.read_data));
        if (got.vector !== want.vector)
            report_mismatch($sformatf("vector %02h, predicted %02h", got.vector, want.vector));
        if (got.cpu_irq !== want.cpu_irq)
            report_mismatch($sformatf("cpu_irq %b, predicted %b", got.cpu_irq, want.cpu_irq));
        if (got.unsupported !== want.unsupported)
            report_mismatch($sformatf("unsupported %b, predicted %b", got.unsupported,
                                      want.unsupported));
    endtask

    // Long response hold-off, counted in its own process
    task automatic hold_response_side(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off <= 1'b0;
    endtask

    // Response side: random stall after each response, held off during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                check_response();
                stall_left = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Traffic
    // ------------------------------------------------------------------

    // Mostly well-formed traffic: line changes, acknowledges, EOIs, reads, masks,
    // full init sequences; the rest is unconstrained noise
    task automatic send_random_traffic(input int count);
        int           target;
        int           pick;
        logic [7:0]   icw1;
        t_pic_request r;
        target = requests_sent + count;
        while (requests_sent < target) begin
            pick = $urandom_range(0, 99);
            r = random_request();
            if (pick < 34) begin
                r.kind = cic_pkg::K_LINE;
            end else if (pick < 54) begin
                r.kind = cic_pkg::K_ACK;
            end else if (pick < 66) begin
                // OCW2, any command code
                r.kind = cic_pkg::K_WRITE;
                r.port = 1'b0;
                r.data[cic_pkg::CMD_ICW1] = 1'b0;
                r.data[cic_pkg::CMD_OCW3] = 1'b0;
            end else if (pick < 76) begin
                r.kind = cic_pkg::K_READ;
            end else if (pick < 81) begin
                // OCW3
                r.kind = cic_pkg::K_WRITE;
                r.port = 1'b0;
                r.data[7] = 1'b0;
                r.data[cic_pkg::CMD_ICW1] = 1'b0;
                r.data[cic_pkg::CMD_OCW3] = 1'b1;
            end else if (pick < 87) begin
                // sparse mask
                r.kind = cic_pkg::K_WRITE;
                r.port = 1'b1;
                r.data = 8'($urandom & $urandom & $urandom);
            end else if (pick < 90) begin
                icw1 = 8'($urandom);
                icw1[cic_pkg::CMD_ICW1] = 1'b1;
                if ($urandom_range(0, 3) != 0)
                    icw1 = (icw1 & ~cic_pkg::ICW1_UNSUP_MASK) | 8'h01;
                send_init_sequence(r.chip, icw1, 8'($urandom), 8'($urandom), 8'($urandom));
                continue;
            end
            send_request(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Master with ICW4, slave with unsupported mode bits and auto EOI
    task automatic test_init_sequences();
        send_init_sequence(1'b0, 8'h11, 8'h20, 8'h04, 8'h01);
        send_init_sequence(1'b1, 8'h1b, 8'h28, 8'h02, 8'h03);
    endtask

    task automatic test_masks_and_reads();
        send_request(write_request(1'b0, 1'b1, 8'hff));
        send_request(read_request(1'b0, 1'b1));
        send_request(write_request(1'b0, 1'b1, 8'h00));
    endtask

    // Direct master request, then a slave request through the cascade line
    task automatic test_cascade_acknowledge();
        send_request(line_request(15, 1'b1));
        send_request(line_request(0, 1'b1));
        send_request(read_request(1'b0, 1'b0));
        send_request(ack_request());
        send_request(write_request(1'b0, 1'b0, 8'h20));
        send_request(ack_request());
        send_request(write_request(1'b0, 1'b0, 8'h0b));
        send_request(read_request(1'b0, 1'b0));
    endtask

    // Specific, rotating and non-specific EOI, priority set, rotate flag, no-op,
    // EOI with nothing in service, and OCW3 poll with special mask
    task automatic test_eoi_commands();
        send_request(write_request(1'b0, 1'b0, 8'h62));
        send_request(write_request(1'b1, 1'b0, 8'he3));
        send_request(write_request(1'b0, 1'b0, 8'hc7));
        send_request(write_request(1'b1, 1'b0, 8'h80));
        send_request(write_request(1'b1, 1'b0, 8'h00));
        send_request(write_request(1'b0, 1'b0, 8'h40));
        send_request(write_request(1'b0, 1'b0, 8'ha0));
        send_request(write_request(1'b0, 1'b0, 8'h6c));
    endtask

    task automatic test_spurious_acknowledge();
        send_request(ack_request());
    endtask

    // Random traffic under both extremes and two other trigger settings
    task automatic test_trigger_settings();
        wait_drained();
        set_trigger_modes(8'hff, 8'hff);
        send_random_traffic(360);
        wait_drained();
        set_trigger_modes(8'h00, 8'h00);
        send_random_traffic(360);
        wait_drained();
        set_trigger_modes(8'($urandom), 8'($urandom));
        send_random_traffic(360);
        wait_drained();
        set_trigger_modes(cic_pkg::ELCR_M_MASK, cic_pkg::ELCR_S_MASK);
        send_random_traffic(360);
    endtask

    // Long response hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        wait_drained();
        steady = 1'b1;
        fork
            hold_response_side(HOLD_CYCLES);
        join_none
        send_random_traffic(40);
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        send_random_traffic(150);
        steady = 1'b1;
        send_random_traffic(150);
        steady = 1'b0;
        send_random_traffic(140);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= cic_pkg::CFG_ELCR_M;
        i_cfg_data         <= 8'h00;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= cic_pkg::K_LINE;
        req_ch.chip_select <= 1'b0;
        req_ch.port        <= 1'b0;
        req_ch.irq_line    <= 4'd0;
        req_ch.level       <= 1'b0;
        req_ch.write_data  <= 8'h00;

        pic[0]         = '0;
        pic[1]         = '0;
        trigger_master = '0;
        trigger_slave  = '0;
        cpu_request    = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_trigger_modes(8'h00, 8'h00);
        test_init_sequences();
        test_masks_and_reads();
        test_cascade_acknowledge();
        test_eoi_commands();
        test_spurious_acknowledge();
        test_trigger_settings();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        $display("Checked %0d responses to %0d requests under %0d trigger settings,",
                 responses_checked, requests_sent, trigger_settings_used);
        $display("with init, EOI, cascade, spurious acknowledge and stall traffic.");
        if (mismatch_count == 0 && predicted_responses.size() == 0) begin
            $display("cascaded_interrupt_controller_tb OK");
        end else begin
            $display("cascaded_interrupt_controller_tb NOT OK");
        end
        $finish;
    end

endmodule
